FILE: rtl/fgn_pkg.sv
// ----------------------------------------------------------------------------
// Fractal gradient noise package
// Shared constants, register indexes and interface types of the fractal
// gradient noise block.
// ----------------------------------------------------------------------------
package fgn_pkg;

    // Sizing of the permutation table, the octave loop and the grid.
    localparam int TABLE_SIZE  = 256;
    localparam int MAX_OCTAVES = 8;
    localparam int GRID_BITS   = 10;

    localparam int TABLE_BITS = $clog2(TABLE_SIZE);
    localparam int OCT_BITS   = $clog2(MAX_OCTAVES + 1);

    // Field and register widths.
    localparam int SCALE_W    = 24;
    localparam int PERS_W     = 17;
    localparam int LAC_W      = 20;
    localparam int OCTCFG_W   = 4;
    localparam int PERM_W     = 8;
    localparam int VALUE_W    = 22;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COORD_SCALE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LACUNARITY   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = CFG_IDX_W'(3);

    // Configuration reset values.
    localparam logic [SCALE_W-1:0]  RST_COORD_SCALE  = SCALE_W'(3277);
    localparam logic [PERS_W-1:0]   RST_PERSISTENCE  = PERS_W'(32768);
    localparam logic [LAC_W-1:0]    RST_LACUNARITY   = LAC_W'(131072);
    localparam logic [OCTCFG_W-1:0] RST_OCTAVE_COUNT = OCTCFG_W'(4);

    // Input transaction kinds.
    localparam logic ACT_TABLE_WR = 1'b0;
    localparam logic ACT_EVAL     = 1'b1;

    // Limits of the signed Q5.16 result.
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Configuration as seen by the evaluation engine.
    typedef struct packed {
        logic [SCALE_W-1:0]  coord_scale;
        logic [PERS_W-1:0]   persistence;
        logic [LAC_W-1:0]    lacunarity;
        logic [OCT_BITS-1:0] octaves;
    } t_cfg;

    // Permutation table write.
    typedef struct packed {
        logic                  we;
        logic [TABLE_BITS-1:0] addr;
        logic [PERM_W-1:0]     data;
    } t_tbl_wr;

    // Control of the evaluation engine.
    typedef struct packed {
        logic                 start;
        logic                 ack;
        logic [GRID_BITS-1:0] grid_x;
        logic [GRID_BITS-1:0] grid_y;
    } t_eval_ctl;

    // Status of the evaluation engine.
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [VALUE_W-1:0] value;
    } t_eval_sts;

endpackage

FILE: rtl/fgn_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, shared by every arithmetic
// step of the noise evaluation.
// ----------------------------------------------------------------------------
module fgn_mul import fgn_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // The product is registered before any post-processing.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/fgn_core.sv
// ----------------------------------------------------------------------------
// Noise evaluation engine
// Sequencer and datapath that sum the octaves of 2D gradient noise for one
// grid point, using the shared multiplier and the permutation table.
// ----------------------------------------------------------------------------
module fgn_core import fgn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_tbl_wr   i_tbl_wr,
    input  t_eval_ctl i_ctl,
    output t_eval_sts o_sts
);

    // Sequencer steps; each step other than idle and done has an issue phase and a write-back phase.
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_AX   = 5'd1;
    localparam logic [4:0] S_AY   = 5'd2;
    localparam logic [4:0] S_NXL  = 5'd3;
    localparam logic [4:0] S_NXH  = 5'd4;
    localparam logic [4:0] S_NYL  = 5'd5;
    localparam logic [4:0] S_NYH  = 5'd6;
    localparam logic [4:0] S_FXA  = 5'd7;
    localparam logic [4:0] S_FXT2 = 5'd8;
    localparam logic [4:0] S_FXT3 = 5'd9;
    localparam logic [4:0] S_FXF  = 5'd10;
    localparam logic [4:0] S_FYA  = 5'd11;
    localparam logic [4:0] S_FYT2 = 5'd12;
    localparam logic [4:0] S_FYT3 = 5'd13;
    localparam logic [4:0] S_FYF  = 5'd14;
    localparam logic [4:0] S_LLO  = 5'd15;
    localparam logic [4:0] S_LHI  = 5'd16;
    localparam logic [4:0] S_LN   = 5'd17;
    localparam logic [4:0] S_TERM = 5'd18;
    localparam logic [4:0] S_AMP  = 5'd19;
    localparam logic [4:0] S_FREQ = 5'd20;
    localparam logic [4:0] S_DONE = 5'd21;

    // Gradient selection codes.
    localparam logic [1:0] GRAD_XPY = 2'd0;
    localparam logic [1:0] GRAD_YMX = 2'd1;
    localparam logic [1:0] GRAD_XMY = 2'd2;
    localparam logic [1:0] GRAD_NXY = 2'd3;

    // Datapath sizing.
    localparam int FRAC     = 16;
    localparam int FACT_W   = 24;
    localparam int AX_W     = GRID_BITS + SCALE_W;
    localparam int AX_LO_W  = MUL_W - 1;
    localparam int AX_HI_W  = AX_W - AX_LO_W;
    localparam int NX_W     = FRAC + TABLE_BITS;
    localparam int NX_SHIFT = AX_LO_W - FRAC;
    localparam int SUM_W    = 32;

    localparam logic [FACT_W-1:0]  Q_ONE     = FACT_W'(65536);
    localparam logic [20:0]        FADE_TEN  = 21'd655360;
    localparam logic signed [MUL_W-1:0] FADE_FIFTEEN = MUL_W'(983040);
    localparam logic signed [17:0] OFF_ONE   = 18'sd65536;

    // Sequencer state.
    logic [4:0]          r_step, n_step;
    logic                r_phase, n_phase;
    logic [OCT_BITS-1:0] r_oct;

    // Datapath registers.
    logic [GRID_BITS-1:0]  r_gx, r_gy;
    logic [AX_W-1:0]       r_ax, r_ay;
    logic [FACT_W-1:0]     r_freq, r_amp;
    logic [NX_W-1:0]       r_nlo, r_nx, r_ny;
    logic [19:0]           r_inner;
    logic [15:0]           r_t2, r_t3;
    logic [16:0]           r_u, r_v;
    logic [PERM_W-1:0]     r_pa, r_pb;
    logic [1:0]            r_h_aa, r_h_ab, r_h_ba, r_h_bb;
    logic signed [18:0]    r_gaa, r_gab;
    logic signed [19:0]    r_dlo, r_dhi;
    logic signed [20:0]    r_lo, r_hi, r_noise;
    logic signed [SUM_W-1:0] r_sum;

    // Permutation table.
    logic [PERM_W-1:0]     r_perm [TABLE_SIZE];
    logic [PERM_W-1:0]     r_rdata;
    logic [TABLE_BITS-1:0] rd_addr;

    // Multiplier connections and derived values.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [15:0]              fade_t;
    logic signed [MUL_W-1:0]  fade_lin;
    logic [TABLE_BITS-1:0]    xi, yi;
    logic signed [17:0]       xf, yf, x1, y1;
    logic [NX_W-1:0]          hi_c;
    logic signed [21:0]       lerp_p;
    logic [27:0]              fact_p;
    logic [FACT_W-1:0]        fact_sat;
    logic signed [21:0]       lo_hi_diff;

    // Gradient dot product for one corner.
    function automatic logic signed [18:0] grad(input logic [1:0] h,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y);
        logic signed [18:0] xe;
        logic signed [18:0] ye;
        xe = 19'(x);
        ye = 19'(y);
        unique case (h)
            GRAD_XPY: grad = xe + ye;
            GRAD_YMX: grad = ye - xe;
            GRAD_XMY: grad = xe - ye;
            GRAD_NXY: grad = -xe - ye;
            default:  grad = xe + ye;
        endcase
    endfunction

    fgn_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Lattice cell and fractional offsets of the sample point.
    assign xi = r_nx[FRAC +: TABLE_BITS];
    assign yi = r_ny[FRAC +: TABLE_BITS];
    assign xf = $signed({2'b00, r_nx[FRAC-1:0]});
    assign yf = $signed({2'b00, r_ny[FRAC-1:0]});
    assign x1 = xf - OFF_ONE;
    assign y1 = yf - OFF_ONE;

    // Fade input and its linear factor 6t - 15.
    assign fade_t   = (r_step >= S_FYA) ? r_ny[FRAC-1:0] : r_nx[FRAC-1:0];
    assign fade_lin = $signed({8'b0, fade_t, 2'b0}) + $signed({9'b0, fade_t, 1'b0})
                      - FADE_FIFTEEN;

    assign lo_hi_diff = 22'(r_hi) - 22'(r_lo);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_step)
            S_AX: begin
                mul_a = $signed(MUL_W'(r_gx));
                mul_b = $signed(MUL_W'(i_cfg.coord_scale));
            end
            S_AY: begin
                mul_a = $signed(MUL_W'(r_gy));
                mul_b = $signed(MUL_W'(i_cfg.coord_scale));
            end
            S_NXL: begin
                mul_a = $signed(MUL_W'(r_ax[AX_LO_W-1:0]));
                mul_b = $signed(MUL_W'(r_freq));
            end
            S_NXH: begin
                mul_a = $signed(MUL_W'(r_ax[AX_W-1 -: AX_HI_W]));
                mul_b = $signed(MUL_W'(r_freq));
            end
            S_NYL: begin
                mul_a = $signed(MUL_W'(r_ay[AX_LO_W-1:0]));
                mul_b = $signed(MUL_W'(r_freq));
            end
            S_NYH: begin
                mul_a = $signed(MUL_W'(r_ay[AX_W-1 -: AX_HI_W]));
                mul_b = $signed(MUL_W'(r_freq));
            end
            S_FXA, S_FYA: begin
                mul_a = $signed(MUL_W'(fade_t));
                mul_b = fade_lin;
            end
            S_FXT2, S_FYT2: begin
                mul_a = $signed(MUL_W'(fade_t));
                mul_b = $signed(MUL_W'(fade_t));
            end
            S_FXT3, S_FYT3: begin
                mul_a = $signed(MUL_W'(r_t2));
                mul_b = $signed(MUL_W'(fade_t));
            end
            S_FXF, S_FYF: begin
                mul_a = $signed(MUL_W'(r_t3));
                mul_b = $signed(MUL_W'(r_inner));
            end
            S_LLO: begin
                mul_a = $signed(MUL_W'(r_u));
                mul_b = MUL_W'(r_dlo);
            end
            S_LHI: begin
                mul_a = $signed(MUL_W'(r_u));
                mul_b = MUL_W'(r_dhi);
            end
            S_LN: begin
                mul_a = $signed(MUL_W'(r_v));
                mul_b = MUL_W'(lo_hi_diff);
            end
            S_TERM: begin
                mul_a = MUL_W'(r_noise);
                mul_b = $signed(MUL_W'(r_amp));
            end
            S_AMP: begin
                mul_a = $signed(MUL_W'(r_amp));
                mul_b = $signed(MUL_W'(i_cfg.persistence));
            end
            S_FREQ: begin
                mul_a = $signed(MUL_W'(r_freq));
                mul_b = $signed(MUL_W'(i_cfg.lacunarity));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Table read address: the two row entries and the four corner hashes are read alongside the fades.
    always_comb begin
        unique case (r_step)
            S_FXA:   rd_addr = xi;
            S_FXT2:  rd_addr = xi + TABLE_BITS'(1);
            S_FXT3:  rd_addr = TABLE_BITS'(r_pa) + yi;
            S_FXF:   rd_addr = TABLE_BITS'(r_pa) + yi + TABLE_BITS'(1);
            S_FYA:   rd_addr = TABLE_BITS'(r_pb) + yi;
            S_FYT2:  rd_addr = TABLE_BITS'(r_pb) + yi + TABLE_BITS'(1);
            default: rd_addr = xi;
        endcase
    end

    // Permutation table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_tbl_wr.we) begin
            r_perm[i_tbl_wr.addr] <= i_tbl_wr.data;
        end
        r_rdata <= r_perm[rd_addr];
    end

    // Post-processing of the registered product.
    assign hi_c     = r_nlo + (prod[NX_W-1:0] << NX_SHIFT);
    assign lerp_p   = $signed(prod[37:16]);
    assign fact_p   = prod[43:16];
    assign fact_sat = (|fact_p[27:FACT_W]) ? '1 : fact_p[FACT_W-1:0];

    // Sequencer: issue in the first phase of a step, write back in the second.
    always_comb begin
        n_step  = r_step;
        n_phase = r_phase;
        priority if (r_step == S_IDLE) begin
            if (i_ctl.start) begin
                n_step  = S_AX;
                n_phase = 1'b0;
            end
        end else if (r_step == S_DONE) begin
            if (i_ctl.ack) begin
                n_step = S_IDLE;
            end
        end else if (!r_phase) begin
            n_phase = 1'b1;
        end else begin
            n_phase = 1'b0;
            if (r_step == S_AY) begin
                n_step = (i_cfg.octaves == '0) ? S_DONE : S_NXL;
            end else if (r_step == S_FREQ) begin
                n_step = (OCT_BITS'(r_oct + 1'b1) == i_cfg.octaves) ? S_DONE : S_NXL;
            end else begin
                n_step = r_step + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_phase <= n_phase;
        end
    end

    // Datapath write-back.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start && (r_step == S_IDLE)) begin
            r_gx   <= i_ctl.grid_x;
            r_gy   <= i_ctl.grid_y;
            r_sum  <= '0;
            r_amp  <= Q_ONE;
            r_freq <= Q_ONE;
            r_oct  <= '0;
        end else if (r_phase) begin
            unique case (r_step)
                S_AX:  r_ax  <= prod[AX_W-1:0];
                S_AY:  r_ay  <= prod[AX_W-1:0];
                S_NXL: r_nlo <= prod[FRAC +: NX_W];
                S_NXH: r_nx  <= hi_c;
                S_NYL: r_nlo <= prod[FRAC +: NX_W];
                S_NYH: r_ny  <= hi_c;
                S_FXA: begin
                    r_inner <= 20'(prod[36:16] + FADE_TEN);
                    r_pa    <= r_rdata;
                end
                S_FXT2: begin
                    r_t2 <= prod[31:16];
                    r_pb <= r_rdata;
                end
                S_FXT3: begin
                    r_t3   <= prod[31:16];
                    r_h_aa <= r_rdata[1:0];
                end
                S_FXF: begin
                    r_u    <= prod[32:16];
                    r_h_ab <= r_rdata[1:0];
                end
                S_FYA: begin
                    r_inner <= 20'(prod[36:16] + FADE_TEN);
                    r_h_ba  <= r_rdata[1:0];
                end
                S_FYT2: begin
                    r_t2   <= prod[31:16];
                    r_h_bb <= r_rdata[1:0];
                end
                S_FYT3: r_t3 <= prod[31:16];
                S_FYF: begin
                    // All hashes are in; form the corner gradients and spans.
                    r_v   <= prod[32:16];
                    r_gaa <= grad(r_h_aa, xf, yf);
                    r_gab <= grad(r_h_ab, xf, y1);
                    r_dlo <= 20'(grad(r_h_ba, x1, yf)) - 20'(grad(r_h_aa, xf, yf));
                    r_dhi <= 20'(grad(r_h_bb, x1, y1)) - 20'(grad(r_h_ab, xf, y1));
                end
                S_LLO:  r_lo    <= 21'(22'(r_gaa) + lerp_p);
                S_LHI:  r_hi    <= 21'(22'(r_gab) + lerp_p);
                S_LN:   r_noise <= 21'(22'(r_lo) + lerp_p);
                S_TERM: r_sum   <= r_sum + $signed(prod[47:16]);
                S_AMP:  r_amp   <= fact_sat;
                S_FREQ: begin
                    r_freq <= fact_sat;
                    r_oct  <= r_oct + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Status, with the octave sum saturated to the result range.
    always_comb begin
        o_sts.busy = (r_step != S_IDLE);
        o_sts.done = (r_step == S_DONE);
        if (r_sum > VALUE_MAX) begin
            o_sts.value = VALUE_MAX;
        end else if (r_sum < VALUE_MIN) begin
            o_sts.value = VALUE_MIN;
        end else begin
            o_sts.value = VALUE_W'(r_sum);
        end
    end

endmodule

FILE: rtl/fractal_gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// Fractal gradient noise, 2D
// Octave-summed gradient noise per grid point, with a loadable permutation
// table and a running minimum and maximum of the results.
// ----------------------------------------------------------------------------
// A table-write transaction returns nothing. An evaluation transaction
// returns one result, and no new transaction is taken until then: the input
// side is ready again in the same cycle as the result appears in the output
// register. The evaluation time is set by the single shared multiplier:
// every multiplication has an issue phase and a write-back phase, and each
// octave needs eighteen of them, with the six permutation table reads
// running alongside the fade steps. The table must be loaded before any
// point that reads an entry is evaluated; configuration is to be written by
// the user only while the block is idle, as the block does not enforce it.
module fractal_gradient_noise_2d import fgn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [PERM_W-1:0]     i_table_index,
    input  logic [PERM_W-1:0]     i_table_value,
    input  logic [GRID_BITS-1:0]  i_grid_x,
    input  logic [GRID_BITS-1:0]  i_grid_y,
    input  logic                  i_first_of_map,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_W-1:0]    o_noise_value,
    output logic [VALUE_W-1:0]    o_min_so_far,
    output logic [VALUE_W-1:0]    o_max_so_far
);

    // Configuration registers.
    logic [SCALE_W-1:0]  r_coord_scale;
    logic [PERS_W-1:0]   r_persistence;
    logic [LAC_W-1:0]    r_lacunarity;
    logic [OCTCFG_W-1:0] r_octave_count;

    // Output register and running extremes.
    logic                      r_out_valid;
    logic [VALUE_W-1:0]        r_out_noise;
    logic signed [VALUE_W-1:0] r_run_min, r_run_max;
    logic                      r_first;

    logic                      accept;
    logic                      handoff;
    logic signed [VALUE_W-1:0] new_val;
    t_cfg                      cfg;
    t_tbl_wr                   tbl_wr;
    t_eval_ctl                 ctl;
    t_eval_sts                 sts;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_scale  <= RST_COORD_SCALE;
            r_persistence  <= RST_PERSISTENCE;
            r_lacunarity   <= RST_LACUNARITY;
            r_octave_count <= RST_OCTAVE_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COORD_SCALE:  r_coord_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_PERSISTENCE:  r_persistence  <= i_cfg_data[PERS_W-1:0];
                CFG_LACUNARITY:   r_lacunarity   <= i_cfg_data[LAC_W-1:0];
                CFG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[OCTCFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Octave counts beyond the supported maximum act as the maximum.
    always_comb begin
        cfg.coord_scale = r_coord_scale;
        cfg.persistence = r_persistence;
        cfg.lacunarity  = r_lacunarity;
        if (r_octave_count > MAX_OCTAVES) begin
            cfg.octaves = OCT_BITS'(MAX_OCTAVES);
        end else begin
            cfg.octaves = OCT_BITS'(r_octave_count);
        end
    end

    // Input transactions go to the table or start an evaluation.
    assign o_in_ready = !sts.busy;
    assign accept     = i_in_valid && o_in_ready;

    assign tbl_wr.we   = accept && (i_action == ACT_TABLE_WR);
    assign tbl_wr.addr = TABLE_BITS'(i_table_index);
    assign tbl_wr.data = i_table_value;

    // A finished result moves on once the output register is free.
    assign handoff    = sts.done && (!r_out_valid || i_out_ready);
    assign ctl.start  = accept && (i_action == ACT_EVAL);
    assign ctl.ack    = handoff;
    assign ctl.grid_x = i_grid_x;
    assign ctl.grid_y = i_grid_y;

    fgn_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_tbl_wr (tbl_wr),
        .i_ctl    (ctl),
        .o_sts    (sts)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.start) begin
            r_first <= i_first_of_map;
        end
    end

    assign new_val = $signed(sts.value);

    // Output valid and running minimum and maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_run_min   <= VALUE_MAX;
            r_run_max   <= VALUE_MIN;
        end else begin
            if (handoff) begin
                r_out_valid <= 1'b1;
                if (r_first) begin
                    r_run_min <= new_val;
                    r_run_max <= new_val;
                end else begin
                    if (new_val < r_run_min) begin
                        r_run_min <= new_val;
                    end
                    if (new_val > r_run_max) begin
                        r_run_max <= new_val;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (handoff) begin
            r_out_noise <= sts.value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_out_noise;
    assign o_min_so_far  = r_run_min;
    assign o_max_so_far  = r_run_max;

endmodule

FILE: dv/fgn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractal gradient noise checker
// Watches the configuration port and both channels of the noise block, keeps
// its own copy of the permutation table, the settings and the running
// extremes, predicts every evaluation result in order and compares it with
// what the block returns.
// ----------------------------------------------------------------------------
module fgn_checker import fgn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_action,
    input  logic [PERM_W-1:0]     i_table_index,
    input  logic [PERM_W-1:0]     i_table_value,
    input  logic [GRID_BITS-1:0]  i_grid_x,
    input  logic [GRID_BITS-1:0]  i_grid_y,
    input  logic                  i_first_of_map,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [VALUE_W-1:0]    i_noise_value,
    input  logic [VALUE_W-1:0]    i_min_so_far,
    input  logic [VALUE_W-1:0]    i_max_so_far,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam longint    Q_ONE        = 65536;
    localparam bit [63:0] FACTOR_LIMIT = 64'd16777215;
    localparam int        REPORT_LIMIT = 10;

    // Corner gradient chosen by the two low bits of the corner hash.
    typedef enum logic [1:0] {
        GRAD_PLUS_PLUS,
        GRAD_MINUS_PLUS,
        GRAD_PLUS_MINUS,
        GRAD_MINUS_MINUS
    } t_gradient;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] lowest;
        logic signed [VALUE_W-1:0] highest;
    } t_noise_result;

    // Mirror of the block's settings and state.
    logic [SCALE_W-1:0]        cfg_scale;
    logic [PERS_W-1:0]         cfg_persistence;
    logic [LAC_W-1:0]          cfg_lacunarity;
    logic [OCTCFG_W-1:0]       cfg_octaves;
    logic [PERM_W-1:0]         perm_mirror [TABLE_SIZE];
    logic signed [VALUE_W-1:0] run_lowest;
    logic signed [VALUE_W-1:0] run_highest;

    t_noise_result             noise_expected_q [$];
    t_noise_result             predicted;
    t_noise_result             oldest;
    int                        mismatches = 0;

    assign o_mismatches = mismatches;

    // Division by 65536 rounded towards minus infinity.
    function automatic longint q16_floor(longint v);
        return v >>> 16;
    endfunction

    // Quintic fade 6t^5 - 15t^4 + 10t^3 in Q0.16.
    function automatic longint fade_curve(longint t);
        longint inner;
        longint t2;
        longint t3;
        inner = q16_floor(t * (6 * t - 15 * Q_ONE)) + 10 * Q_ONE;
        t2    = q16_floor(t * t);
        t3    = q16_floor(t2 * t);
        return q16_floor(t3 * inner);
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + q16_floor(t * (b - a));
    endfunction

    function automatic longint corner_gradient(logic [PERM_W-1:0] h, longint x, longint y);
        case (t_gradient'(h[1:0]))
            GRAD_PLUS_PLUS:  return x + y;
            GRAD_MINUS_PLUS: return y - x;
            GRAD_PLUS_MINUS: return x - y;
            default:         return -x - y;
        endcase
    endfunction

    function automatic logic [PERM_W-1:0] perm_lookup(int unsigned i);
        return perm_mirror[i % TABLE_SIZE];
    endfunction

    // Frequency and amplitude update, saturating at the Q8.16 limit.
    function automatic bit [63:0] scale_sat(bit [63:0] v, bit [63:0] factor);
        bit [63:0] p;
        p = (v * factor) >> 16;
        return (p > FACTOR_LIMIT) ? FACTOR_LIMIT : p;
    endfunction

    // One octave of gradient noise at a Q16.16 sample point.
    function automatic longint gradient_noise(bit [63:0] nx, bit [63:0] ny);
        int unsigned xi;
        int unsigned yi;
        int unsigned pa;
        int unsigned pb;
        logic [PERM_W-1:0] aa;
        logic [PERM_W-1:0] ab;
        logic [PERM_W-1:0] ba;
        logic [PERM_W-1:0] bb;
        longint xf;
        longint yf;
        longint u;
        longint v;
        longint lo;
        longint hi;
        xi = 32'((nx >> 16) % TABLE_SIZE);
        yi = 32'((ny >> 16) % TABLE_SIZE);
        xf = nx[15:0];
        yf = ny[15:0];
        u  = fade_curve(xf);
        v  = fade_curve(yf);
        pa = perm_lookup(xi);
        pb = perm_lookup((xi + 1) % TABLE_SIZE);
        aa = perm_lookup(pa + yi);
        ab = perm_lookup(pa + yi + 1);
        ba = perm_lookup(pb + yi);
        bb = perm_lookup(pb + yi + 1);
        lo = blend(corner_gradient(aa, xf, yf), corner_gradient(ba, xf - Q_ONE, yf), u);
        hi = blend(corner_gradient(ab, xf, yf - Q_ONE),
                   corner_gradient(bb, xf - Q_ONE, yf - Q_ONE), u);
        return blend(lo, hi, v);
    endfunction

    // Octave sum at one grid point, saturated to the signed Q5.16 range.
    function automatic logic signed [VALUE_W-1:0] fbm_noise_at(logic [GRID_BITS-1:0] gx,
                                                              logic [GRID_BITS-1:0] gy);
        bit [63:0] freq;
        bit [63:0] amp;
        bit [63:0] nx;
        bit [63:0] ny;
        longint    total;
        int        octaves;
        int        k;
        freq    = Q_ONE;
        amp     = Q_ONE;
        total   = 0;
        octaves = (cfg_octaves > MAX_OCTAVES) ? MAX_OCTAVES : cfg_octaves;
        for (k = 0; k < octaves; k++) begin
            nx    = (64'(gx) * 64'(cfg_scale) * freq) >> 16;
            ny    = (64'(gy) * 64'(cfg_scale) * freq) >> 16;
            total = total + q16_floor(gradient_noise(nx, ny) * longint'(amp));
            amp   = scale_sat(amp, 64'(cfg_persistence));
            freq  = scale_sat(freq, 64'(cfg_lacunarity));
        end
        if (total > VALUE_MAX) total = VALUE_MAX;
        if (total < VALUE_MIN) total = VALUE_MIN;
        return total[VALUE_W-1:0];
    endfunction

    // Everything is sampled at the rising edge, so inputs driven at the same
    // edge are seen with their previous values, just as the block sees them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_scale       = RST_COORD_SCALE;
            cfg_persistence = RST_PERSISTENCE;
            cfg_lacunarity  = RST_LACUNARITY;
            cfg_octaves     = RST_OCTAVE_COUNT;
            run_lowest      = VALUE_MAX;
            run_highest     = VALUE_MIN;
            noise_expected_q.delete();
            o_pending      <= 0;
        end else begin
            // Register writes; bits above a register's width are dropped.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COORD_SCALE:  cfg_scale       = i_cfg_data[SCALE_W-1:0];
                    CFG_PERSISTENCE:  cfg_persistence = i_cfg_data[PERS_W-1:0];
                    CFG_LACUNARITY:   cfg_lacunarity  = i_cfg_data[LAC_W-1:0];
                    CFG_OCTAVE_COUNT: cfg_octaves     = i_cfg_data[OCTCFG_W-1:0];
                    default: ;
                endcase
            end

            // Input transaction: a table write, or an evaluation to predict.
            if (i_in_valid && i_in_ready) begin
                if (i_action == ACT_TABLE_WR) begin
                    perm_mirror[i_table_index] = i_table_value;
                end else begin
                    predicted.value = fbm_noise_at(i_grid_x, i_grid_y);
                    if (i_first_of_map) begin
                        run_lowest  = predicted.value;
                        run_highest = predicted.value;
                    end else begin
                        if (predicted.value < run_lowest)  run_lowest  = predicted.value;
                        if (predicted.value > run_highest) run_highest = predicted.value;
                    end
                    predicted.lowest  = run_lowest;
                    predicted.highest = run_highest;
                    noise_expected_q.push_back(predicted);
                end
            end

            // Output transaction against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (noise_expected_q.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: unexpected result: value %0d min %0d max %0d", $realtime,
                                 $signed(i_noise_value), $signed(i_min_so_far),
                                 $signed(i_max_so_far));
                    mismatches++;
                end else begin
                    oldest = noise_expected_q.pop_front();
                    if (i_noise_value !== oldest.value || i_min_so_far !== oldest.lowest ||
                        i_max_so_far !== oldest.highest) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("%0t: mismatch: expected value %0d min %0d max %0d, got %0d %0d %0d",
                                     $realtime, oldest.value, oldest.lowest, oldest.highest,
                                     $signed(i_noise_value), $signed(i_min_so_far),
                                     $signed(i_max_so_far));
                        mismatches++;
                    end
                end
            end

            o_pending <= noise_expected_q.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractal gradient noise testbench
// Loads a shuffled permutation table, runs a directed set of grid points at
// the reset settings, then a series of phases with different register
// settings and handshake idling. Results are checked by the checker module.
// ----------------------------------------------------------------------------
module testbench;
    import fgn_pkg::*;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES   = 8;
    localparam logic [GRID_BITS-1:0] GRID_LAST = '1;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_action;
    logic [PERM_W-1:0]     i_table_index;
    logic [PERM_W-1:0]     i_table_value;
    logic [GRID_BITS-1:0]  i_grid_x;
    logic [GRID_BITS-1:0]  i_grid_y;
    logic                  i_first_of_map;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [VALUE_W-1:0]    o_noise_value;
    logic [VALUE_W-1:0]    o_min_so_far;
    logic [VALUE_W-1:0]    o_max_so_far;

    int                    idle_pct  = 0;
    int                    stall_pct = 0;
    int                    mismatches;
    int                    pending;

    fractal_gradient_noise_2d u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .i_grid_x       (i_grid_x),
        .i_grid_y       (i_grid_y),
        .i_first_of_map (i_first_of_map),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_noise_value  (o_noise_value),
        .o_min_so_far   (o_min_so_far),
        .o_max_so_far   (o_max_so_far)
    );

    fgn_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .i_grid_x       (i_grid_x),
        .i_grid_y       (i_grid_y),
        .i_first_of_map (i_first_of_map),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_noise_value  (o_noise_value),
        .i_min_so_far   (o_min_so_far),
        .i_max_so_far   (o_max_so_far),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver side: ready is withdrawn at random according to the phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Writes all four registers, with junk above each register's width where the
    // data port is wider, plus one write to an index past the last register.
    task automatic apply_settings(input logic [SCALE_W-1:0] scale, input logic [PERS_W-1:0] pers,
                                 input logic [LAC_W-1:0] lac, input logic [OCTCFG_W-1:0] oct);
        cfg_write(CFG_COORD_SCALE, CFG_DATA_W'(scale));
        cfg_write(CFG_PERSISTENCE, CFG_DATA_W'(($urandom << PERS_W) | pers));
        cfg_write(CFG_LACUNARITY, CFG_DATA_W'(($urandom << LAC_W) | lac));
        cfg_write(CFG_OCTAVE_COUNT, CFG_DATA_W'(($urandom << OCTCFG_W) | oct));
        cfg_write(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_OCTAVE_COUNT + 1)),
                  CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Offers one transaction, with an optional idle gap in front, and returns
    // at the edge where it is accepted. Valid is left high for the next one.
    task automatic send_item(input logic act, input logic [PERM_W-1:0] idx,
                             input logic [PERM_W-1:0] val, input logic [GRID_BITS-1:0] gx,
                             input logic [GRID_BITS-1:0] gy, input logic first);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_table_index  <= idx;
        i_table_value  <= val;
        i_grid_x       <= gx;
        i_grid_y       <= gy;
        i_first_of_map <= first;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Holds the sender back until every result has come, then lets the block
    // settle before the registers may be touched.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [PERM_W-1:0]    shuffled [TABLE_SIZE];
        logic [PERM_W-1:0]    swap;
        logic [SCALE_W-1:0]   scale;
        logic [GRID_BITS-1:0] gx;
        logic [GRID_BITS-1:0] gy;
        t_idle_mode           mode;
        int                   j;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_action       = ACT_TABLE_WR;
        i_table_index  = '0;
        i_table_value  = '0;
        i_grid_x       = '0;
        i_grid_y       = '0;
        i_first_of_map = 1'b0;

        // Random permutation for the table.
        for (int i = 0; i < TABLE_SIZE; i++) shuffled[i] = PERM_W'(i);
        for (int i = TABLE_SIZE - 1; i > 0; i--) begin
            j           = $urandom_range(i);
            swap        = shuffled[i];
            shuffled[i] = shuffled[j];
            shuffled[j] = swap;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every entry is written before any point is evaluated.
        for (int i = 0; i < TABLE_SIZE; i++)
            send_item(ACT_TABLE_WR, PERM_W'(i), shuffled[i], GRID_BITS'($urandom),
                      GRID_BITS'($urandom), 1'($urandom));

        // Directed points at the reset settings. The first one does not
        // restart the map, so it is compared with the reset extremes.
        send_item(ACT_EVAL, '0, '0, '0, '0, 1'b0);
        send_item(ACT_EVAL, '1, '1, GRID_LAST, GRID_LAST, 1'b0);
        send_item(ACT_EVAL, '0, '1, '0, GRID_LAST, 1'b0);
        send_item(ACT_EVAL, '1, '0, GRID_LAST, '0, 1'b1);
        send_item(ACT_EVAL, '0, '0, GRID_BITS'(10'h2AA), GRID_BITS'(10'h155), 1'b0);
        send_item(ACT_EVAL, '0, '0, GRID_BITS'(10'h155), GRID_BITS'(10'h2AA), 1'b0);
        send_item(ACT_EVAL, '0, '0, GRID_BITS'(1), GRID_BITS'(1), 1'b0);
        send_item(ACT_TABLE_WR, '0, '1, GRID_BITS'(10'h155), GRID_BITS'(10'h2AA), 1'b1);
        send_item(ACT_TABLE_WR, '1, '0, GRID_BITS'(10'h2AA), GRID_BITS'(10'h155), 1'b0);
        send_item(ACT_EVAL, '0, '0, '0, '0, 1'b0);
        send_item(ACT_EVAL, '0, '0, GRID_LAST, GRID_LAST, 1'b1);
        send_item(ACT_EVAL, '0, '0, GRID_BITS'(512), GRID_BITS'(511), 1'b0);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            mode      = t_idle_mode'(p % 4);
            idle_pct  = (mode == IDLE_SENDER) ? 49 : (mode == IDLE_BOTH) ? 15 : 0;
            stall_pct <= (mode == IDLE_RECEIVER) ? 49 : (mode == IDLE_BOTH) ? 15 : 0;

            scale = $urandom_range(1) ? SCALE_W'($urandom_range(1, 70000)) : SCALE_W'($urandom);
            case (p)
                0:       apply_settings('0, '1, '1, OCTCFG_W'(MAX_OCTAVES));
                1:       apply_settings('1, '0, '0, '1);
                2:       apply_settings(scale, PERS_W'($urandom), LAC_W'($urandom), '0);
                3:       apply_settings(scale, PERS_W'($urandom), LAC_W'($urandom),
                                        OCTCFG_W'(1));
                4:       apply_settings(scale, '1, LAC_W'($urandom_range(65536, 196608)),
                                        OCTCFG_W'(MAX_OCTAVES));
                default: apply_settings(scale, PERS_W'($urandom),
                                        $urandom_range(1) ? LAC_W'($urandom)
                                                          : LAC_W'($urandom_range(65536, 196608)),
                                        OCTCFG_W'($urandom_range(1, 6)));
            endcase

            // Mostly evaluations, some table rewrites and corner points.
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 15) begin
                    send_item(ACT_TABLE_WR, PERM_W'($urandom), PERM_W'($urandom),
                              GRID_BITS'($urandom), GRID_BITS'($urandom), 1'($urandom));
                end else begin
                    gx = ($urandom_range(9) == 0) ? {GRID_BITS{1'($urandom_range(1))}}
                                                  : GRID_BITS'($urandom);
                    gy = ($urandom_range(9) == 0) ? {GRID_BITS{1'($urandom_range(1))}}
                                                  : GRID_BITS'($urandom);
                    send_item(ACT_EVAL, PERM_W'($urandom), PERM_W'($urandom), gx, gy,
                              $urandom_range(15) == 0);
                end
            end
            drain_results();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
